### rtl/core/ptdc_pkg.sv
// Shared constants and controller/datapath interface types for the palindromic tree block.
package ptdc_pkg;

	localparam int MAX_LEN     = 4096;
	localparam int ALPHA       = 26;
	localparam int NODES       = MAX_LEN + 2;
	localparam int CHILD_DEPTH = NODES * ALPHA;
	localparam int SYM_W       = 5;
	localparam int NODE_W      = $clog2(NODES);
	localparam int POS_W       = $clog2(MAX_LEN + 1);
	localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

	localparam logic [NODE_W-1:0] EVEN_ROOT = NODE_W'(0);
	localparam logic [NODE_W-1:0] ODD_ROOT  = NODE_W'(1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRD,
		ST_WIDX,
		ST_WCMP,
		ST_CRD,
		ST_CCHK,
		ST_QRD,
		ST_QCHK,
		ST_FIN
	} ptdc_state_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic walk_rd;
		logic walk_idx;
		logic walk_step;
		logic latch_rt;
		logic latch_q;
		logic rd_child_q;
		logic create;
		logic take_child;
		logic link_new;
		logic out_load;
	} ptdc_cmd_t;

	typedef struct packed {
		logic full;
		logic bad_sym;
		logic odd_hit;
		logic match;
		logic grow;
		logic clr_done;
		logic out_busy;
	} ptdc_status_t;

endpackage

### rtl/core/palindromic_tree_distinct_count.sv
// Top level of the streaming palindromic tree that counts distinct palindromes.
//
//  channel  | handshake                    | payload
//  symbol   | symbol_valid / symbol_stall  | symbol[4:0]
//  result   | result_valid / result_stall  | distinct_palindromes[12:0], overflow
//
// A dropped word (history full or symbol above 25) is taken, then the result is loaded.
// Otherwise the word is taken; each node tried on the suffix-link walk is read, its
// history entry read and compared (the odd root ends the walk without a read); then the
// child is looked up and the result loaded. A new node adds a second walk, a child read
// and the link write. After reset the child table is swept clear, one entry a cycle,
// all 106548 entries, during which symbol_stall stays high.
// One word is in work at a time; a new word is taken while a result waits.
module palindromic_tree_distinct_count
	import ptdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              symbol_valid,
	output logic              symbol_stall,
	input  logic [SYM_W-1:0]  symbol,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [NODE_W-1:0] distinct_palindromes,
	output logic              overflow
);

	ptdc_cmd_t    cmd;
	ptdc_status_t status;

	ptdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol_valid (symbol_valid),
		.status       (status),
		.symbol_stall (symbol_stall),
		.cmd          (cmd)
	);

	ptdc_dpath u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.symbol               (symbol),
		.result_stall         (result_stall),
		.status               (status),
		.result_valid         (result_valid),
		.distinct_palindromes (distinct_palindromes),
		.overflow             (overflow)
	);

endmodule

### rtl/core/ptdc_ctrl.sv
// Sequencer for the palindromic tree: clearing sweep, suffix-link walks and node creation.
module ptdc_ctrl
	import ptdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         symbol_valid,
	input  ptdc_status_t status,
	output logic         symbol_stall,
	output ptdc_cmd_t    cmd
);

	ptdc_state_t state_q, state_d;
	logic        walk2_q, walk2_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			walk2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			walk2_q <= walk2_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		walk2_d      = walk2_q;
		cmd          = '0;
		symbol_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				symbol_stall = 1'b0;
				if (symbol_valid) begin
					cmd.accept = 1'b1;
					walk2_d    = 1'b0;
					if (status.full || status.bad_sym) state_d = ST_FIN;
					else state_d = ST_WRD;
				end
			end
			ST_WRD: begin
				// odd root always mirrors: finish without reading
				if (status.odd_hit) begin
					if (walk2_q) begin
						cmd.latch_q = 1'b1;
						state_d     = ST_QRD;
					end else begin
						cmd.latch_rt = 1'b1;
						state_d      = ST_CRD;
					end
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = ST_WIDX;
				end
			end
			ST_WIDX: begin
				cmd.walk_idx = 1'b1;
				state_d      = ST_WCMP;
			end
			ST_WCMP: begin
				if (status.match) begin
					if (walk2_q) begin
						cmd.latch_q = 1'b1;
						state_d     = ST_QRD;
					end else begin
						cmd.latch_rt = 1'b1;
						state_d      = ST_CRD;
					end
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = ST_WRD;
				end
			end
			ST_CRD: begin
				state_d = ST_CCHK;
			end
			ST_CCHK: begin
				if (status.grow) begin
					cmd.create = 1'b1;
					walk2_d    = 1'b1;
					state_d    = ST_WRD;
				end else begin
					cmd.take_child = 1'b1;
					state_d        = ST_FIN;
				end
			end
			ST_QRD: begin
				cmd.rd_child_q = 1'b1;
				state_d        = ST_QCHK;
			end
			ST_QCHK: begin
				cmd.link_new = 1'b1;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				// hold while the previous word is still waiting
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.create |=> state_q == ST_WRD && walk2_q)
		else $error("node creation did not start the link walk");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == ST_IDLE && !symbol_stall)
		else $error("word taken outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE)
		else $error("result loaded without returning to idle");

endmodule

### rtl/core/ptdc_dpath.sv
// Datapath of the palindromic tree: history, node tables, child table and result register.
module ptdc_dpath
	import ptdc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ptdc_cmd_t           cmd,
	input  logic [SYM_W-1:0]    symbol,
	input  logic                result_stall,
	output ptdc_status_t        status,
	output logic                result_valid,
	output logic [NODE_W-1:0]   distinct_palindromes,
	output logic                overflow
);

	logic [SYM_W-1:0]  hist_mem  [MAX_LEN+1];
	logic [NODE_W-1:0] len_mem   [NODES];
	logic [NODE_W-1:0] link_mem  [NODES];
	logic [NODE_W-1:0] child_mem [CHILD_DEPTH];

	logic [SYM_W-1:0]    sym_q, hist_rd_q;
	logic [POS_W-1:0]    position_q, pos_q;
	logic [NODE_W-1:0]   count_q, current_q, v_q, rt_q, qn_q, newv_q;
	logic [NODE_W-1:0]   len_rd_q, link_rd_q, child_rd_q;
	logic [NODE_W-1:0]   len_eff_q, link_eff_q, rt_newlen_q, rt_link_q;
	logic                idx_ok_q, ovf_q, even_rd_q;
	logic [CHILD_AW-1:0] clr_cnt_q;

	logic [NODE_W-1:0]   len_eff, link_eff;
	logic [POS_W:0]      len_p1;
	logic [POS_W-1:0]    idx;
	logic                idx_ok;
	logic [CHILD_AW-1:0] child_addr, rt_addr, q_addr;
	logic                child_we;
	logic [NODE_W-1:0]   child_wd;
	logic [NODE_W-1:0]   count_p1;

	assign count_p1 = count_q + NODE_W'(1);
	assign rt_addr  = CHILD_AW'(rt_q * ALPHA) + CHILD_AW'(sym_q);
	assign q_addr   = CHILD_AW'(qn_q * ALPHA) + CHILD_AW'(sym_q);

	// roots are not kept in the node tables
	assign len_eff  = even_rd_q ? NODE_W'(0) : len_rd_q;
	assign link_eff = even_rd_q ? ODD_ROOT : link_rd_q;
	assign len_p1   = {1'b0, len_eff} + (POS_W+1)'(1);
	assign idx_ok   = len_p1 < {1'b0, pos_q};
	assign idx      = pos_q - len_p1[POS_W-1:0];

	always_comb begin
		child_we   = 1'b0;
		child_wd   = rt_q;
		child_addr = rt_addr;
		if (cmd.clr_wr) begin
			child_we   = 1'b1;
			child_wd   = EVEN_ROOT;
			child_addr = clr_cnt_q;
		end else if (cmd.rd_child_q) begin
			child_addr = q_addr;
		end else if (cmd.link_new) begin
			child_we = 1'b1;
			child_wd = newv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_addr] <= child_wd;
		child_rd_q <= child_mem[child_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !status.full && !status.bad_sym)
			hist_mem[position_q + POS_W'(1)] <= symbol;
		hist_rd_q <= hist_mem[idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.create) len_mem[count_p1] <= rt_newlen_q;
		if (cmd.link_new) link_mem[newv_q] <= child_rd_q;
		len_rd_q  <= len_mem[v_q];
		link_rd_q <= link_mem[v_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q <= symbol;
			ovf_q <= status.full;
			pos_q <= position_q + POS_W'(1);
		end
		if (cmd.walk_rd) even_rd_q <= (v_q == EVEN_ROOT);
		if (cmd.walk_idx) begin
			len_eff_q  <= len_eff;
			link_eff_q <= link_eff;
			idx_ok_q   <= idx_ok;
		end
		if (cmd.latch_rt) begin
			rt_q        <= v_q;
			rt_newlen_q <= status.odd_hit ? NODE_W'(1) : len_eff_q + NODE_W'(2);
			rt_link_q   <= status.odd_hit ? ODD_ROOT : link_eff_q;
		end
		if (cmd.latch_q) qn_q <= v_q;
		if (cmd.create) newv_q <= count_p1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q            <= '0;
			position_q           <= '0;
			count_q              <= NODE_W'(1);
			current_q            <= EVEN_ROOT;
			v_q                  <= EVEN_ROOT;
			result_valid         <= 1'b0;
			distinct_palindromes <= '0;
			overflow             <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_cnt_q <= clr_cnt_q + CHILD_AW'(1);
			if (cmd.accept) v_q <= current_q;
			if (cmd.walk_step) v_q <= link_eff_q;
			if (cmd.create) begin
				count_q <= count_p1;
				v_q     <= rt_link_q;
			end
			if (cmd.take_child) begin
				current_q  <= child_rd_q;
				position_q <= pos_q;
			end
			if (cmd.link_new) begin
				current_q  <= newv_q;
				position_q <= pos_q;
			end
			if (cmd.out_load) begin
				result_valid         <= 1'b1;
				distinct_palindromes <= count_q - NODE_W'(1);
				overflow             <= ovf_q;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		status          = '0;
		status.full     = position_q >= POS_W'(MAX_LEN);
		status.bad_sym  = symbol >= SYM_W'(ALPHA);
		status.odd_hit  = v_q == ODD_ROOT;
		status.match    = idx_ok_q && (hist_rd_q == sym_q);
		status.grow     = (child_rd_q == EVEN_ROOT) && (32'(count_p1) < NODES);
		status.clr_done = clr_cnt_q == CHILD_AW'(CHILD_DEPTH - 1);
		status.out_busy = result_valid && result_stall;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) < NODES)
		else $error("node count beyond table");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(position_q) <= MAX_LEN)
		else $error("position beyond history");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.create |=> count_q == $past(count_q) + NODE_W'(1))
		else $error("node count not advanced on creation");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(current_q) <= 32'(count_q))
		else $error("current node not yet created");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the streaming palindromic tree distinct-palindrome counter.
module tb_top;
	import ptdc_pkg::*;

	localparam int LIMIT = 6000000;

	logic              clk;
	logic              arst_n;
	logic              symbol_valid;
	logic              symbol_stall;
	logic [SYM_W-1:0]  symbol;
	logic              result_valid;
	logic              result_stall;
	logic [NODE_W-1:0] distinct_palindromes;
	logic              overflow;

	typedef struct {
		logic [NODE_W-1:0] count;
		logic              ovf;
	} count_result_t;

	logic [SYM_W-1:0] pending_syms[$];
	count_result_t    expected_counts[$];

	// tree predictor state
	logic [SYM_W-1:0] tr_hist[0:MAX_LEN];
	int unsigned      tr_child[0:CHILD_DEPTH-1];
	int               tr_len[0:NODES-1];
	int unsigned      tr_link[0:NODES-1];
	int unsigned      tr_nodes;
	int unsigned      tr_cur;
	int unsigned      tr_pos;

	int unsigned gen_pos;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          fail_count;
	int          cycle_count;
	bit          took;

	palindromic_tree_distinct_count u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.symbol_valid         (symbol_valid),
		.symbol_stall         (symbol_stall),
		.symbol               (symbol),
		.result_valid         (result_valid),
		.result_stall         (result_stall),
		.distinct_palindromes (distinct_palindromes),
		.overflow             (overflow)
	);

	function automatic int unsigned find_mirror(int unsigned v, int unsigned p);
		int idx;
		for (int s = 0; s < NODES + 2; s++) begin
			if (v >= NODES) return ODD_ROOT;
			idx = int'(p) - tr_len[v] - 1;
			if (idx >= 0 && idx <= int'(p) && tr_hist[idx] == tr_hist[p]) return v;
			v = tr_link[v];
		end
		return ODD_ROOT;
	endfunction

	function automatic count_result_t extend_tree(logic [SYM_W-1:0] sym);
		count_result_t r;
		int unsigned p, rt, q, v;
		r.ovf = 1'b0;
		if (tr_pos >= MAX_LEN) begin
			r.ovf = 1'b1;
		end else if (sym < ALPHA) begin
			p = tr_pos + 1;
			tr_hist[p] = sym;
			rt = find_mirror(tr_cur, p);
			if (tr_child[rt*ALPHA + sym] == 0 && tr_nodes + 1 < NODES) begin
				v = tr_nodes + 1;
				tr_nodes = v;
				tr_len[v] = tr_len[rt] + 2;
				q = find_mirror(tr_link[rt], p);
				tr_link[v] = tr_child[q*ALPHA + sym];
				tr_child[rt*ALPHA + sym] = v;
			end
			tr_cur = tr_child[rt*ALPHA + sym];
			if (tr_cur >= NODES) tr_cur = EVEN_ROOT;
			tr_pos = p;
		end
		r.count = NODE_W'(tr_nodes - 1);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// accept words, predict, and check results
	always @(posedge clk) begin
		count_result_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("palindromic_tree_distinct_count: mismatch");
			$finish;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (expected_counts.size() == 0) begin
				$error("result with no word outstanding");
				fail_count++;
			end else begin
				want = expected_counts.pop_front();
				if (distinct_palindromes !== want.count) begin
					$error("distinct_palindromes expected %0d got %0d", want.count,
						distinct_palindromes);
					fail_count++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow expected %0d got %0d", want.ovf, overflow);
					fail_count++;
				end
			end
		end
		if (arst_n && symbol_valid && !symbol_stall) begin
			expected_counts = {expected_counts, extend_tree(symbol)};
			took = 1'b1;
		end
	end

	// drive the sender and the receiver stall
	always @(negedge clk) begin
		if (!symbol_valid || took) begin
			if (pending_syms.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				symbol_valid <= 1'b1;
				symbol <= pending_syms.pop_front();
			end else begin
				symbol_valid <= 1'b0;
			end
		end
		took = 1'b0;
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic queue_symbol(logic [SYM_W-1:0] s);
		pending_syms = {pending_syms, s};
		if (s < ALPHA && gen_pos < MAX_LEN) gen_pos++;
	endtask

	task automatic drain();
		while (pending_syms.size() != 0 || symbol_valid || expected_counts.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int n, int sidle, int rstall);
		int alpha;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		alpha = 1;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				alpha = ($urandom_range(9) == 0) ? ALPHA : $urandom_range(1, 4);
			if ($urandom_range(9) == 0)
				queue_symbol(SYM_W'($urandom_range(ALPHA, 31)));
			else
				queue_symbol(SYM_W'($urandom_range(alpha - 1)));
		end
		// hold off until every result is back
		drain();
	endtask

	initial begin
		logic [SYM_W-1:0] directed[] = '{0, 25, 26, 31, 0, 0, 0, 1, 0, 1, 27, 2, 1, 0, 1,
			2, 25, 25, 30, 3, 3, 25, 0, 16, 15};
		arst_n = 1'b0;
		symbol_valid = 1'b0;
		symbol = '0;
		result_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		gen_pos = 0;
		took = 1'b0;
		for (int i = 0; i < CHILD_DEPTH; i++) tr_child[i] = 0;
		for (int i = 0; i < NODES; i++) begin
			tr_len[i] = 0;
			tr_link[i] = 0;
		end
		for (int i = 0; i <= MAX_LEN; i++) tr_hist[i] = '0;
		tr_hist[0] = 5'd31;
		tr_len[ODD_ROOT] = -1;
		tr_link[EVEN_ROOT] = ODD_ROOT;
		tr_link[ODD_ROOT] = ODD_ROOT;
		tr_nodes = 1;
		tr_cur = EVEN_ROOT;
		tr_pos = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (directed[i]) queue_symbol(directed[i]);
		drain();
		random_phase(250, 0, 0);
		random_phase(250, 61, 0);
		random_phase(250, 0, 61);
		random_phase(250, 21, 21);
		// fill the history to its end, then push past it
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (gen_pos < MAX_LEN) queue_symbol(SYM_W'($urandom_range(1)));
		for (int i = 0; i < 12; i++) queue_symbol(SYM_W'($urandom_range(31)));
		queue_symbol(5'd0);
		queue_symbol(5'd31);
		drain();
		random_phase(20, 21, 21);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("palindromic_tree_distinct_count: match");
		else
			$display("palindromic_tree_distinct_count: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/core/ptdc_pkg.sv
rtl/core/ptdc_ctrl.sv
rtl/core/ptdc_dpath.sv
rtl/core/palindromic_tree_distinct_count.sv
tb/tb_top.sv
